/* design/ble_adv_sensor_data_parser_defines.svh */
// ---------------------------------------------------------------------------
// BLE advertisement sensor data parser: assertion macros
// Shared property wrappers for the checker of the parser.
// ---------------------------------------------------------------------------
`ifndef BLE_ADV_SENSOR_DATA_PARSER_DEFINES_SVH
`define BLE_ADV_SENSOR_DATA_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BASDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BASDP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/basdp_pkg.sv */
// ---------------------------------------------------------------------------
// BLE advertisement sensor data parser: package
// Bus widths, item codes and the item size lookup.
// ---------------------------------------------------------------------------
package basdp_pkg;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [7:0] AD_SERVICE_DATA = 8'h16;
  localparam logic [7:0] UUID_LO         = 8'hD2;
  localparam logic [7:0] UUID_HI         = 8'hFC;
  localparam logic [7:0] FLAGS_MASK      = 8'hE1;  // version field and encryption bit
  localparam logic [7:0] FLAGS_V2_PLAIN  = 8'h40;  // version 2, unencrypted
  localparam logic [7:0] MIN_SVC_REM     = 8'd5;

  localparam logic [7:0] ITEM_PACKET_ID = 8'h00;
  localparam logic [7:0] ITEM_BATTERY   = 8'h01;
  localparam logic [7:0] ITEM_HUMIDITY  = 8'h2E;
  localparam logic [7:0] ITEM_BUTTON    = 8'h3A;
  localparam logic [7:0] ITEM_TEMP      = 8'h45;
  localparam logic [7:0] BUTTON_PRESS   = 8'h01;

  typedef logic [1:0] item_size_t;

  function automatic item_size_t item_size(input logic [7:0] code);
    item_size_t n;
    unique case (code)
      ITEM_PACKET_ID, ITEM_BATTERY, ITEM_HUMIDITY, ITEM_BUTTON: n = 2'd1;
      ITEM_TEMP:                                                 n = 2'd2;
      default:                                                   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

/* design/ble_adv_sensor_data_parser.sv */
// Sensor advertisement parser. Each input transaction carries one advertisement
// byte and the count of bytes left in the packet, this byte included. The block
// takes one byte per cycle unless a held result stalls input: the whole element
// walk is a single next-state update of the parse registers, so the parse state
// loop sets the rate of one byte per clock. A result transaction follows in the
// cycle after the last byte of a packet (bytes left equal to one) and reports the
// stored readings and the error flag. A held result does not stall input while
// the output register is free or being taken in the same cycle.
// ---------------------------------------------------------------------------
// BLE advertisement sensor data parser
// Walks length-type elements and decodes sensor items from service data.
// ---------------------------------------------------------------------------
module ble_adv_sensor_data_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] adv_byte, [15:8] bytes_left
  input  logic [basdp_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] packet_id, [15:8] battery_level, [23:16] humidity,
  // [39:24] temperature, [40] button_pressed, [41] parse_error, [47:42] zero
  output logic [basdp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import basdp_pkg::*;

  localparam logic [2:0] PH_LEN   = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_SKIP  = 3'd2;
  localparam logic [2:0] PH_HDR   = 3'd3;
  localparam logic [2:0] PH_ITYPE = 3'd4;
  localparam logic [2:0] PH_IDATA = 3'd5;
  localparam logic [2:0] PH_DROP  = 3'd6;

  logic [2:0]  phase_r, phase_nxt, step_next;
  logic [7:0]  elem_r, elem_nxt;
  logic [1:0]  hdr_r, hdr_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [1:0]  irem_r, irem_nxt;
  logic [7:0]  tlow_r, tlow_nxt;
  logic [7:0]  pid_r, pid_nxt;
  logic [7:0]  batt_r, batt_nxt;
  logic [7:0]  hum_r, hum_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic        btn_r, btn_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [7:0]  b, left, after, rem;
  item_size_t  isz;
  logic        in_accept, last_byte;

  assign b         = in_tdata[7:0];
  assign left      = in_tdata[15:8];
  assign last_byte = (left == 8'd1);
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign after     = (left == 8'd0) ? 8'd0 : left - 8'd1;
  assign rem       = elem_r - 8'd1;
  assign isz       = item_size(b);

  always_comb begin
    phase_nxt = phase_r;
    elem_nxt  = elem_r;
    hdr_nxt   = hdr_r;
    code_nxt  = code_r;
    irem_nxt  = irem_r;
    tlow_nxt  = tlow_r;
    pid_nxt   = pid_r;
    batt_nxt  = batt_r;
    hum_nxt   = hum_r;
    temp_nxt  = temp_r;
    btn_nxt   = btn_r;
    err_nxt   = err_r;
    step_next = phase_r;

    if (phase_r == PH_LEN) begin
      if (b == 8'd0 || b > after) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_DROP;
      end else begin
        elem_nxt  = b;
        phase_nxt = PH_TYPE;
      end
    end else if (phase_r != PH_DROP) begin
      if (elem_r == 8'd0) begin
        phase_nxt = PH_LEN;
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            step_next = (b == AD_SERVICE_DATA && rem >= MIN_SVC_REM) ? PH_HDR : PH_SKIP;
            hdr_nxt   = 2'd0;
          end
          PH_HDR: begin
            priority if (hdr_r == 2'd0) begin
              if (b == UUID_LO) hdr_nxt = 2'd1;
              else step_next = PH_SKIP;
            end else if (hdr_r == 2'd1) begin
              if (b == UUID_HI) hdr_nxt = 2'd2;
              else step_next = PH_SKIP;
            end else begin
              if ((b & FLAGS_MASK) == FLAGS_V2_PLAIN) begin
                pid_nxt   = 8'd0;
                batt_nxt  = 8'd0;
                hum_nxt   = 8'd0;
                temp_nxt  = 16'd0;
                btn_nxt   = 1'b0;
                err_nxt   = 1'b0;
                step_next = PH_ITYPE;
              end else begin
                step_next = PH_SKIP;
              end
              hdr_nxt = 2'd0;
            end
          end
          PH_ITYPE: begin
            priority if (isz == 2'd0) begin
              err_nxt   = 1'b1;
              step_next = PH_SKIP;
            end else if (rem < {6'd0, isz}) begin
              step_next = PH_SKIP;
            end else begin
              code_nxt  = b;
              irem_nxt  = isz;
              step_next = PH_IDATA;
            end
          end
          PH_IDATA: begin
            if (code_r == ITEM_TEMP && irem_r == 2'd2) begin
              tlow_nxt = b;
            end else begin
              unique case (code_r)
                ITEM_PACKET_ID: pid_nxt  = b;
                ITEM_BATTERY:   batt_nxt = b;
                ITEM_HUMIDITY:  hum_nxt  = b;
                ITEM_TEMP:      temp_nxt = {b, tlow_r};
                default:        btn_nxt  = (b == BUTTON_PRESS);
              endcase
            end
            irem_nxt = irem_r - 2'd1;
            if (irem_nxt == 2'd0) step_next = PH_ITYPE;
          end
          default: ;
        endcase
        elem_nxt  = rem;
        phase_nxt = (rem == 8'd0) ? PH_LEN : step_next;
      end
    end

    if (last_byte) begin
      phase_nxt = PH_LEN;
      elem_nxt  = 8'd0;
      hdr_nxt   = 2'd0;
      code_nxt  = 8'd0;
      irem_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      elem_r      <= 8'd0;
      hdr_r       <= 2'd0;
      code_r      <= 8'd0;
      irem_r      <= 2'd0;
      tlow_r      <= 8'd0;
      pid_r       <= 8'd0;
      batt_r      <= 8'd0;
      hum_r       <= 8'd0;
      temp_r      <= 16'd0;
      btn_r       <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r <= phase_nxt;
        elem_r  <= elem_nxt;
        hdr_r   <= hdr_nxt;
        code_r  <= code_nxt;
        irem_r  <= irem_nxt;
        tlow_r  <= tlow_nxt;
        pid_r   <= pid_nxt;
        batt_r  <= batt_nxt;
        hum_r   <= hum_nxt;
        temp_r  <= temp_nxt;
        btn_r   <= btn_nxt;
        err_r   <= err_nxt;
      end
      if (in_accept && last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      out_data_r <= {6'd0, err_nxt, btn_nxt, temp_nxt, hum_nxt, batt_nxt, pid_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/basdp_checker.sv */
// ---------------------------------------------------------------------------
// BLE advertisement sensor data parser: port checker
// Watches the stream ports of the parser over time.
// ---------------------------------------------------------------------------
`include "ble_adv_sensor_data_parser_defines.svh"

module basdp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  // [7:0] adv_byte, [15:8] bytes_left
  input logic [basdp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  // [7:0] packet_id, [15:8] battery_level, [23:16] humidity,
  // [39:24] temperature, [40] button_pressed, [41] parse_error, [47:42] zero
  input logic [basdp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import basdp_pkg::*;

  logic last_accept;
  assign last_accept = in_tvalid && in_tready && (in_tdata[15:8] == 8'd1);

  `BASDP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `BASDP_ASSERT_NXT(a_last_gives_result, last_accept, out_tvalid, "no result after last byte")
  `BASDP_ASSERT_IMP(a_ready_when_free, !out_tvalid || out_tready, in_tready, "input stalled with output free")
  `BASDP_ASSERT_IMP(a_result_from_last, $rose(out_tvalid), $past(last_accept), "result without last byte")

endmodule

bind ble_adv_sensor_data_parser basdp_checker u_basdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
